// ===== hdl/mbr_partition_table_scanner_macros.svh =====
// Assertion macros for the MBR partition table scanner.
`ifndef MBR_PARTITION_TABLE_SCANNER_MACROS_SVH
`define MBR_PARTITION_TABLE_SCANNER_MACROS_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define MBR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MBR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mbr_pkg.sv =====
// Package: constants, types and helper functions of the MBR partition table scanner.
`default_nettype none
package mbr_pkg;

  localparam logic [8:0] TABLE_START  = 9'd446;
  localparam logic [8:0] SIG_POS      = 9'd510;
  localparam logic [8:0] SIG_HIGH_POS = 9'd511;
  localparam logic [7:0] SIG_LOW_VAL  = 8'h55;
  localparam logic [7:0] SIG_HIGH_VAL = 8'hAA;
  localparam logic [7:0] TYPE_GPT     = 8'hEE;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned TABLE_AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned ENTRIES     = 4;

  // Bytes fetched per entry: type, 4 bytes start, 4 bytes count.
  localparam logic [3:0] FETCH_BYTES = 4'd9;
  localparam logic [1:0] LAST_ENTRY  = 2'd3;

  localparam logic [2:0] CLASS_RAW    = 3'd0;
  localparam logic [2:0] CLASS_FAT    = 3'd1;
  localparam logic [2:0] CLASS_NTFS   = 3'd2;
  localparam logic [2:0] CLASS_LINUX  = 3'd3;
  localparam logic [2:0] CLASS_NATIVE = 3'd4;
  localparam logic [2:0] CLASS_GPT    = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_EMIT,
    ST_EMPTY
  } scan_state_t;

  function automatic logic [2:0] fs_class_of(input logic [7:0] ptype);
    logic [2:0] cls;
    unique case (ptype)
      8'h01, 8'h04, 8'h06, 8'h0B, 8'h0C, 8'h0E: cls = CLASS_FAT;
      8'h07: cls = CLASS_NTFS;
      8'h83: cls = CLASS_LINUX;
      8'h99: cls = CLASS_NATIVE;
      8'hEE: cls = CLASS_GPT;
      default: cls = CLASS_RAW;
    endcase
    return cls;
  endfunction

  // Byte offset inside a 16-byte entry for fetch step k:
  // step 0 is the type byte, steps 1..8 are bytes 8..15.
  function automatic logic [3:0] fetch_offset(input logic [3:0] k);
    logic [3:0] off;
    if (k == 4'd0) begin
      off = 4'd4;
    end else begin
      off = 4'(k + 4'd7);
    end
    return off;
  endfunction

  function automatic logic [1:0] lowest_index(input logic [3:0] m);
    logic [1:0] idx;
    priority if (m[0]) idx = 2'd0;
    else if (m[1]) idx = 2'd1;
    else if (m[2]) idx = 2'd2;
    else idx = 2'd3;
    return idx;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/mbr_if.sv =====
// Channel interfaces: sector byte input, result output, configuration write.
`default_nettype none

interface mbr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface mbr_out_if;
  logic        valid;
  logic        ready;
  logic        entry_valid;
  logic        signature_ok;
  logic [2:0]  entry_number;
  logic [7:0]  partition_type;
  logic [31:0] first_sector;
  logic [31:0] sector_count;
  logic [2:0]  fs_class;
  logic        protective_gpt;
  logic        last;
  modport source (output valid, output entry_valid, output signature_ok,
                  output entry_number, output partition_type, output first_sector,
                  output sector_count, output fs_class, output protective_gpt,
                  output last, input ready);
  modport sink   (input valid, input entry_valid, input signature_ok,
                  input entry_number, input partition_type, input first_sector,
                  input sector_count, input fs_class, input protective_gpt,
                  input last, output ready);
endinterface

interface mbr_cfg_if;
  logic        valid;
  logic        ready;
  logic [47:0] device_block_count;
  modport source (output valid, output device_block_count, input ready);
  modport sink   (input valid, input device_block_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/mbr_partition_table_scanner.sv =====
// Top level: MBR partition table scanner with table memory and scan sequencer.
//
//  channel  dir  payload                              request
//  -------  ---  -----------------------------------  ---------------------------
//  cfg      in   device_block_count[47:0]             valid & ready (always ready)
//  sector   in   data_byte[7:0]                       valid & ready
//  result   out  entry/type/start/count/class/flags   valid & ready
//
//  One sector byte per cycle is taken while sector.ready is high. Bytes
//  446..509 go into a 64x8 table memory (one write port, one registered
//  read port). After byte 511 the sequencer walks the table twice through
//  the read port: a check pass over all four entries and an emit pass over
//  the valid entries, which output stalls can hold; a bad signature goes
//  straight to one result. During the scan only bytes 0..445 of the next
//  sector are taken, since they do not touch the table. Results sit in an
//  output register.
//  rst is synchronous and clears the position, signature byte, register
//  and control state; the table needs no clearing.
`default_nettype none
`include "mbr_partition_table_scanner_macros.svh"

module mbr_partition_table_scanner
  import mbr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  mbr_cfg_if.sink     cfg,
  mbr_in_if.sink      sector,
  mbr_out_if.source   result
);

  scan_state_t state, state_next;

  logic [8:0]  pos;         // byte position within the sector
  logic [7:0]  sig_low;     // byte 510
  logic [47:0] dbc;         // device block count
  logic        sig_ok;

  // Table memory
  logic [7:0]          table_mem [TABLE_DEPTH];
  logic [7:0]          rd_data;
  logic [TABLE_AW-1:0] rd_addr;
  logic [TABLE_AW-1:0] wr_addr;
  logic                tbl_we;

  // Scan sequencer
  logic [1:0]  entry;       // current slot, 0-based
  logic [3:0]  rd_cnt;      // fetch step, 0..FETCH_BYTES
  logic        pass2;       // 0: check pass, 1: emit pass
  logic [3:0]  valid_mask;  // check-pass verdicts
  logic [3:0]  pending;     // valid entries not yet emitted
  logic        prot;
  logic [71:0] gather;      // {count, start, type} little-endian

  logic        in_fire;
  logic        out_free;
  logic        sig_now;

  // Entry check on the gathered fields
  logic [7:0]  g_type;
  logic [31:0] g_start;
  logic [31:0] g_count;
  logic [47:0] room;
  logic        entry_ok;
  logic [3:0]  mask_after;
  logic [3:0]  pending_rest;

  assign cfg.ready    = 1'b1;
  // Bytes below the table can be taken while a scan is running.
  assign sector.ready = (state == ST_IDLE) || (pos < TABLE_START);
  assign in_fire      = sector.valid && sector.ready;
  assign out_free     = !result.valid || result.ready;
  assign sig_now      = (sig_low == SIG_LOW_VAL) && (sector.data_byte == SIG_HIGH_VAL);

  assign tbl_we  = in_fire && (pos >= TABLE_START) && (pos < SIG_POS);
  assign wr_addr = TABLE_AW'(pos - TABLE_START);
  assign rd_addr = {entry, fetch_offset(rd_cnt)};

  assign g_type   = gather[7:0];
  assign g_start  = gather[39:8];
  assign g_count  = gather[71:40];
  assign room     = dbc - {16'd0, g_start};
  assign entry_ok = (g_type != 8'd0) && (g_count != 32'd0) && (g_start != 32'd0) &&
                    ({16'd0, g_start} < dbc) && ({16'd0, g_count} <= room);

  assign mask_after   = valid_mask | (4'(entry_ok) << entry);
  assign pending_rest = pending & ~(4'b0001 << entry);

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      table_mem[wr_addr] <= sector.data_byte;
    end
    rd_data <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && (pos == SIG_HIGH_POS)) begin
          state_next = sig_now ? ST_READ : ST_EMPTY;
        end
      end
      ST_READ: begin
        if (rd_cnt == FETCH_BYTES) begin
          state_next = pass2 ? ST_EMIT : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if ((entry == LAST_ENTRY) && (mask_after == 4'd0)) begin
          state_next = ST_EMPTY;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = (pending_rest == 4'd0) ? ST_IDLE : ST_READ;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Position, signature byte and register
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      sig_low <= '0;
      dbc     <= '0;
    end else begin
      if (in_fire) begin
        pos <= pos + 9'd1;
        if (pos == SIG_POS) begin
          sig_low <= sector.data_byte;
        end
      end
      if (cfg.valid) begin
        dbc <= cfg.device_block_count;
      end
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_fire && (pos == SIG_HIGH_POS)) begin
          sig_ok     <= sig_now;
          entry      <= 2'd0;
          rd_cnt     <= 4'd0;
          pass2      <= 1'b0;
          valid_mask <= 4'd0;
          prot       <= 1'b0;
        end
      end
      ST_READ: begin
        // read data is registered, so it lags its address
        if (rd_cnt != 4'd0) begin
          gather <= {rd_data, gather[71:8]};
        end
        if (rd_cnt != FETCH_BYTES) begin
          rd_cnt <= rd_cnt + 4'd1;
        end
      end
      ST_CHECK: begin
        valid_mask <= mask_after;
        if (entry_ok && (g_type == TYPE_GPT)) begin
          prot <= 1'b1;
        end
        rd_cnt <= 4'd0;
        if (entry == LAST_ENTRY) begin
          pass2   <= 1'b1;
          pending <= mask_after;
          entry   <= lowest_index(mask_after);
        end else begin
          entry <= entry + 2'd1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          pending <= pending_rest;
          entry   <= lowest_index(pending_rest);
          rd_cnt  <= 4'd0;
        end
      end
      ST_EMPTY: ;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free) begin
      result.valid <= (state == ST_EMIT) || (state == ST_EMPTY);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (state == ST_EMIT) begin
        result.entry_valid    <= 1'b1;
        result.signature_ok   <= 1'b1;
        result.entry_number   <= {1'b0, entry} + 3'd1;
        result.partition_type <= g_type;
        result.first_sector   <= g_start;
        result.sector_count   <= g_count;
        result.fs_class       <= fs_class_of(g_type);
        result.protective_gpt <= prot;
        result.last           <= (pending_rest == 4'd0);
      end else if (state == ST_EMPTY) begin
        result.entry_valid    <= 1'b0;
        result.signature_ok   <= sig_ok;
        result.entry_number   <= 3'd0;
        result.partition_type <= 8'd0;
        result.first_sector   <= 32'd0;
        result.sector_count   <= 32'd0;
        result.fs_class       <= CLASS_RAW;
        result.protective_gpt <= 1'b0;
        result.last           <= 1'b1;
      end
    end
  end

  `MBR_ASSERT_NOW(a_no_table_write_in_scan, in_fire && (state != ST_IDLE), pos < TABLE_START, "table byte taken during scan")
  `MBR_ASSERT_NOW(a_emit_pending, state == ST_EMIT, pending[entry], "emitting an entry that is not pending")
  `MBR_ASSERT_NOW(a_empty_is_last, result.valid && !result.entry_valid, result.last, "empty result without last")
  `MBR_ASSERT_NOW(a_fetch_bound, state == ST_READ, rd_cnt <= FETCH_BYTES, "fetch step out of range")
  `MBR_ASSERT_NEXT(a_scan_start, (state == ST_IDLE) && in_fire && (pos == SIG_HIGH_POS), (state == ST_READ) || (state == ST_EMPTY), "scan not started after byte 511")

endmodule
`default_nettype wire

// ===== tb/mbr_partition_table_scanner_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the MBR partition table scanner: sector streams, predictor and result checks.
module mbr_partition_table_scanner_tb;
  import mbr_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 120;     // check pass plus four emits, with margin
  localparam int unsigned HOLD_CYCLES  = 1500;    // long enough to back up into the sector input
  localparam int unsigned CYCLE_LIMIT  = 800000;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam logic [47:0] BLOCKS_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam longint unsigned LBA_MAX  = 64'hFFFF_FFFF;

  // One partition report as it leaves the block.
  typedef struct packed {
    logic        entry_valid;
    logic        signature_ok;
    logic [2:0]  entry_number;
    logic [7:0]  partition_type;
    logic [31:0] first_sector;
    logic [31:0] sector_count;
    logic [2:0]  fs_class;
    logic        protective_gpt;
    logic        last;
  } report_t;

  // One table slot as written into the sector.
  typedef struct packed {
    logic [7:0]  ptype;
    logic [31:0] lba;
    logic [31:0] span;
  } part_t;

  // Mirrors the scanner: follows the byte stream, decodes the table at byte 511
  // and queues the reports the block owes, oldest first.
  class partition_ledger;
    logic [8:0]  byte_pos;
    logic [7:0]  table_copy [64];
    logic [7:0]  sig_low;
    logic [47:0] dev_blocks;
    report_t     pending_reports [$];
    int unsigned predicted;
    int unsigned errors;

    function new();
      byte_pos   = '0;
      sig_low    = '0;
      dev_blocks = '0;
      predicted  = 0;
      errors     = 0;
      foreach (table_copy[i]) table_copy[i] = '0;
    endfunction

    function logic [31:0] le32(int unsigned off);
      return {table_copy[off + 3], table_copy[off + 2], table_copy[off + 1], table_copy[off]};
    endfunction

    function logic [2:0] class_of_type(logic [7:0] t);
      case (t)
        8'h01, 8'h04, 8'h06, 8'h0B, 8'h0C, 8'h0E: return CLASS_FAT;
        8'h07: return CLASS_NTFS;
        8'h83: return CLASS_LINUX;
        8'h99: return CLASS_NATIVE;
        8'hEE: return CLASS_GPT;
        default: return CLASS_RAW;
      endcase
    endfunction

    // Range must sit inside the device: start in 1..blocks-1, count up to what is left.
    function bit range_fits(logic [7:0] t, logic [31:0] start, logic [31:0] cnt);
      longint unsigned st;
      longint unsigned dev;
      st  = start;
      dev = dev_blocks;
      if (t == 8'h00 || cnt == 0 || st == 0 || st >= dev) return 0;
      return longint'(cnt) <= dev - st;
    endfunction

    function void take_byte(logic [7:0] b);
      logic [8:0]  pos;
      logic        sig_ok;
      logic        gpt;
      logic [7:0]  ptype [4];
      logic [31:0] lba [4];
      logic [31:0] span [4];
      bit          ok [4];
      int          n_ok;
      int          n_out;
      report_t     r;
      pos      = byte_pos;
      byte_pos = pos + 9'd1;
      if (pos >= TABLE_START && pos < SIG_POS) begin
        table_copy[pos - TABLE_START] = b;
        return;
      end
      if (pos == SIG_POS) begin
        sig_low = b;
        return;
      end
      if (pos != SIG_HIGH_POS) return;
      sig_ok = (sig_low == SIG_LOW_VAL) && (b == SIG_HIGH_VAL);
      gpt    = 1'b0;
      n_ok   = 0;
      for (int i = 0; i < 4; i++) begin
        ptype[i] = table_copy[16 * i + 4];
        lba[i]   = le32(16 * i + 8);
        span[i]  = le32(16 * i + 12);
        ok[i]    = sig_ok && range_fits(ptype[i], lba[i], span[i]);
        if (ok[i]) begin
          n_ok++;
          if (ptype[i] == TYPE_GPT) gpt = 1'b1;
        end
      end
      // bad signature or empty table: a single all-zero report
      if (n_ok == 0) begin
        r              = '0;
        r.signature_ok = sig_ok;
        r.last         = 1'b1;
        pending_reports.push_back(r);
        predicted++;
        return;
      end
      n_out = 0;
      for (int i = 0; i < 4; i++) begin
        if (ok[i]) begin
          n_out++;
          r.entry_valid    = 1'b1;
          r.signature_ok   = 1'b1;
          r.entry_number   = 3'(i + 1);
          r.partition_type = ptype[i];
          r.first_sector   = lba[i];
          r.sector_count   = span[i];
          r.fs_class       = class_of_type(ptype[i]);
          r.protective_gpt = gpt;
          r.last           = (n_out == n_ok);
          pending_reports.push_back(r);
          predicted++;
        end
      end
    endfunction

    function string show(report_t r);
      return $sformatf("valid=%0d sig=%0d slot=%0d type=%h first=%h count=%h class=%0d gpt=%0d last=%0d",
                       r.entry_valid, r.signature_ok, r.entry_number, r.partition_type,
                       r.first_sector, r.sector_count, r.fs_class, r.protective_gpt, r.last);
    endfunction

    function void match_report(report_t got);
      report_t want;
      if (pending_reports.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) $display("unexpected report: %s", show(got));
        return;
      end
      want = pending_reports.pop_front();
      if (got.entry_valid !== want.entry_valid || got.signature_ok !== want.signature_ok ||
          got.entry_number !== want.entry_number || got.partition_type !== want.partition_type ||
          got.first_sector !== want.first_sector || got.sector_count !== want.sector_count ||
          got.fs_class !== want.fs_class || got.protective_gpt !== want.protective_gpt ||
          got.last !== want.last) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("report mismatch");
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int unsigned cycles;
  int unsigned src_idle_pct;      // sender idle rate, percent
  int unsigned snk_idle_pct;      // receiver stall rate, percent
  int unsigned hold_requests;     // bumped by the stimulus to ask for one long receiver stall
  partition_ledger ledger = new();

  mbr_cfg_if cfg_ch ();
  mbr_in_if  sec_ch ();
  mbr_out_if res_ch ();

  mbr_partition_table_scanner uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sector (sec_ch),
    .result (res_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Watchdog on the whole run.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("mbr_partition_table_scanner_tb: errors");
      $finish;
    end
  end

  // Result side: check each accepted report, then pick ready for the next edge.
  // A pending hold request turns into a long stall counted here.
  initial begin : result_sink
    int unsigned hold_taken;
    int unsigned hold_left;
    report_t got;
    res_ch.ready = 1'b0;
    hold_taken   = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        got.entry_valid    = res_ch.entry_valid;
        got.signature_ok   = res_ch.signature_ok;
        got.entry_number   = res_ch.entry_number;
        got.partition_type = res_ch.partition_type;
        got.first_sector   = res_ch.first_sector;
        got.sector_count   = res_ch.sector_count;
        got.fs_class       = res_ch.fs_class;
        got.protective_gpt = res_ch.protective_gpt;
        got.last           = res_ch.last;
        ledger.match_report(got);
      end
      if (hold_taken != hold_requests) begin
        hold_taken = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // One sector byte request; the ledger sees it at the accepting edge.
  // valid stays high afterwards so back-to-back bytes need no second write.
  task send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      sec_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sec_ch.valid     <= 1'b1;
    sec_ch.data_byte <= b;
    do @(posedge clk); while (!sec_ch.ready);
    ledger.take_byte(b);
  endtask

  // Full 512-byte sector: random boot code, the four slots, then the signature.
  // Slot bytes other than type, LBA and count are random filler.
  task stream_sector(input part_t a, input part_t b, input part_t c, input part_t d,
                     input logic [7:0] s_lo, input logic [7:0] s_hi);
    part_t      ent [4];
    logic [7:0] v;
    int         off;
    int         k;
    ent[0] = a;
    ent[1] = b;
    ent[2] = c;
    ent[3] = d;
    for (int p = 0; p < 512; p++) begin
      v = 8'($urandom);
      if (p >= TABLE_START && p < SIG_POS) begin
        off = p - TABLE_START;
        k   = off % 16;
        if (k == 4) v = ent[off / 16].ptype;
        else if (k >= 8 && k < 12) v = ent[off / 16].lba[8 * (k - 8) +: 8];
        else if (k >= 12) v = ent[off / 16].span[8 * (k - 12) +: 8];
      end else if (p == SIG_POS) begin
        v = s_lo;
      end else if (p == SIG_HIGH_POS) begin
        v = s_hi;
      end
      send_byte(v);
    end
  endtask

  // Wait until every owed report is out, then give the sequencer time to settle.
  task wait_idle();
    sec_ch.valid <= 1'b0;
    while (ledger.pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_blocks(input logic [47:0] blocks);
    cfg_ch.valid              <= 1'b1;
    cfg_ch.device_block_count <= blocks;
    do @(posedge clk); while (!cfg_ch.ready);
    ledger.dev_blocks = blocks;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic longint unsigned rand_in(longint unsigned lo, longint unsigned hi);
    longint unsigned r;
    r = {$urandom, $urandom};
    return lo + r % (hi - lo + 1);
  endfunction

  // Device sizes: empty, tiny, around the 32-bit LBA edge, random, full 48 bits.
  function automatic logic [47:0] pick_blocks();
    case ($urandom_range(7))
      0: return 48'd0;
      1: return 48'd1;
      2: return 48'($urandom_range(2, 5000));
      3: return 48'hFFFF_FFFF + 48'($urandom_range(0, 2));
      4: return 48'({$urandom, $urandom});
      5: return BLOCKS_MAX;
      default: return 48'($urandom_range(2, 100000));
    endcase
  endfunction

  // Random slot, mostly in range for the current device, with the boundary
  // cases mixed in: zero type, zero start, zero count, start past the end,
  // count one past the end, count exactly to the end.
  function automatic part_t random_slot(logic [47:0] blocks);
    part_t           s;
    longint unsigned dev;
    longint unsigned top;
    longint unsigned room;
    int unsigned     kind;
    dev = blocks;
    case ($urandom_range(11))
      0: s.ptype = 8'h01;
      1: s.ptype = 8'h04;
      2: s.ptype = 8'h06;
      3: s.ptype = 8'h07;
      4: s.ptype = 8'h0B;
      5: s.ptype = 8'h0C;
      6: s.ptype = 8'h0E;
      7: s.ptype = 8'h83;
      8: s.ptype = 8'h99;
      9: s.ptype = 8'hEE;
      default: s.ptype = 8'($urandom);
    endcase
    s.lba  = $urandom;
    s.span = $urandom;
    kind   = $urandom_range(9);
    if (dev >= 2) begin
      top   = (dev - 1 < LBA_MAX) ? dev - 1 : LBA_MAX;
      s.lba = 32'(rand_in(1, top));
      room  = dev - s.lba;
      if (room > LBA_MAX) room = LBA_MAX;
      s.span = 32'(rand_in(1, room));
      case (kind)
        0: s.ptype = 8'h00;
        5: s.span = 32'(room);
        6: s.lba = 32'd0;
        7: s.span = 32'd0;
        8: if (dev <= LBA_MAX) s.lba = 32'(rand_in(dev, LBA_MAX));
        9: if (dev - s.lba + 1 <= LBA_MAX) s.span = 32'(dev - s.lba + 1);
        default: ;
      endcase
    end
    return s;
  endfunction

  initial begin : stimulus
    int unsigned base;
    int unsigned idx;
    logic [47:0] blocks;
    logic [7:0]  s_lo;
    logic [7:0]  s_hi;
    part_t       sl [4];

    rst                       = 1'b1;
    cfg_ch.valid              = 1'b0;
    cfg_ch.device_block_count = '0;
    sec_ch.valid              = 1'b0;
    sec_ch.data_byte          = '0;
    hold_requests             = 0;
    src_idle_pct              = 17;
    snk_idle_pct              = 52;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed sectors ---
    // empty device: nothing can fit, one empty report with good signature
    write_blocks(48'd0);
    stream_sector({8'h01, 32'd1, 32'd1}, {8'h07, 32'd2, 32'd1}, {8'h83, 32'd3, 32'd1},
                  {8'hEE, 32'd4, 32'd1}, SIG_LOW_VAL, SIG_HIGH_VAL);
    wait_idle();

    // full 48-bit device: all four slots, FAT, NTFS, Linux and native classes
    write_blocks(BLOCKS_MAX);
    stream_sector({8'h01, 32'd1, 32'd100}, {8'h07, 32'd100, 32'd1000},
                  {8'h83, 32'd5000, 32'hFFFF}, {8'h99, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                  SIG_LOW_VAL, SIG_HIGH_VAL);
    // protective GPT plus zero start and zero count slots
    stream_sector({8'hEE, 32'd1, 32'hFFFF_FFFF}, {8'h04, 32'd2, 32'd3},
                  {8'h06, 32'd0, 32'd5}, {8'h0B, 32'd7, 32'd0}, SIG_LOW_VAL, SIG_HIGH_VAL);
    stream_sector({8'h0C, 32'd10, 32'd10}, {8'h0E, 32'd20, 32'd20},
                  {8'h00, 32'd30, 32'd30}, {8'h42, 32'd40, 32'd40}, SIG_LOW_VAL, SIG_HIGH_VAL);
    // broken signatures: entries are never looked at
    stream_sector({8'h01, 32'd1, 32'd100}, {8'h07, 32'd100, 32'd1000},
                  {8'h83, 32'd5000, 32'hFFFF}, {8'hEE, 32'd9, 32'd9}, 8'h54, SIG_HIGH_VAL);
    stream_sector({8'h01, 32'd1, 32'd100}, {8'h07, 32'd100, 32'd1000},
                  {8'h83, 32'd5000, 32'hFFFF}, {8'hEE, 32'd9, 32'd9}, SIG_LOW_VAL, 8'hAB);
    stream_sector({8'h01, 32'd1, 32'd100}, {8'h07, 32'd100, 32'd1000},
                  {8'h83, 32'd5000, 32'hFFFF}, {8'hEE, 32'd9, 32'd9}, SIG_HIGH_VAL, SIG_LOW_VAL);
    // good signature, nothing valid
    stream_sector({8'h00, 32'd1, 32'd1}, {8'h07, 32'd0, 32'd1},
                  {8'h83, 32'd1, 32'd0}, {8'h00, 32'd0, 32'd0}, SIG_LOW_VAL, SIG_HIGH_VAL);
    wait_idle();

    // small device: ranges right at the end
    write_blocks(48'd1000);
    stream_sector({8'h83, 32'd999, 32'd1}, {8'h83, 32'd1000, 32'd1},
                  {8'h07, 32'd500, 32'd500}, {8'h07, 32'd500, 32'd501}, SIG_LOW_VAL, SIG_HIGH_VAL);
    // GPT slot out of range must not raise the protective flag
    stream_sector({8'hEE, 32'd1001, 32'd1}, {8'h0C, 32'd1, 32'd999},
                  {8'h01, 32'd1, 32'd1000}, {8'h99, 32'd998, 32'd2}, SIG_LOW_VAL, SIG_HIGH_VAL);
    wait_idle();

    // device just past the 32-bit LBA range
    write_blocks(48'h1_0000_0000);
    stream_sector({8'h01, 32'hFFFF_FFFF, 32'd1}, {8'h01, 32'hFFFF_FFFE, 32'd2},
                  {8'h07, 32'hFFFF_FFFF, 32'd2}, {8'h83, 32'd1, 32'hFFFF_FFFF},
                  SIG_LOW_VAL, SIG_HIGH_VAL);
    wait_idle();

    // two-block device: only LBA 1 length 1 fits
    write_blocks(48'd2);
    stream_sector({8'h01, 32'd1, 32'd1}, {8'h01, 32'd1, 32'd2},
                  {8'h01, 32'd2, 32'd1}, {8'hEE, 32'd1, 32'd1}, SIG_LOW_VAL, SIG_HIGH_VAL);

    // --- random sectors ---
    // Idling runs sender-light, then receiver-light, then none. The device
    // size changes every four sectors while the block is idle.
    base   = ledger.predicted;
    idx    = 0;
    blocks = 48'd2;
    while (ledger.predicted - base < 60 || idx < 24) begin
      if (idx % 4 == 0) begin
        wait_idle();
        if (idx < 8) begin
          src_idle_pct = 17;
          snk_idle_pct = 52;
        end else if (idx < 16) begin
          src_idle_pct = 52;
          snk_idle_pct = 17;
        end else begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
        blocks = pick_blocks();
        write_blocks(blocks);
      end
      // long receiver stall while the sender keeps streaming the next sector
      if (idx == 17) hold_requests++;
      foreach (sl[i]) sl[i] = random_slot(blocks);
      s_lo = SIG_LOW_VAL;
      s_hi = SIG_HIGH_VAL;
      if ($urandom_range(99) < 15) begin
        case ($urandom_range(2))
          0: s_lo = 8'($urandom);
          1: s_hi = 8'($urandom);
          default: begin
            s_lo = 8'($urandom);
            s_hi = 8'($urandom);
          end
        endcase
      end
      stream_sector(sl[0], sl[1], sl[2], sl[3], s_lo, s_hi);
      idx++;
    end

    wait_idle();
    if (ledger.errors == 0 && ledger.pending_reports.size() == 0) begin
      $display("mbr_partition_table_scanner_tb: clean");
    end else begin
      $display("mbr_partition_table_scanner_tb: errors");
    end
    $finish;
  end

endmodule
